### design/generational_handle_allocator_top_defines.svh
// ---------------------------------------------------------------------------
// Generational handle allocator - assertion macros
// Shared property wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define GHA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GHA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/gha_pkg.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - package
// Sizes, function and status codes, controller/datapath command types.
// ---------------------------------------------------------------------------
package gha_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int GEN_BITS   = 16;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = IDX_W + 1;
	localparam int FUNC_W     = 3;
	localparam int STATUS_W   = 3;

	localparam logic [GEN_BITS-1:0] GEN_ONE   = GEN_BITS'(1);
	// a slot whose generation reaches this on reuse is retired
	localparam logic [GEN_BITS-1:0] GEN_LIMIT = ~GEN_BITS'(1);

	typedef enum logic [FUNC_W-1:0] {
		FN_CREATE = 3'd0,
		FN_FREE   = 3'd1,
		FN_CHECK  = 3'd2,
		FN_CLEAR  = 3'd3,
		FN_FIRST  = 3'd4,
		FN_NEXT   = 3'd5
	} gha_func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_LIVE  = 3'd1,
		ST_FULL      = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_NONE      = 3'd4
	} gha_status_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_POP_GEN,
		CMD_FIN_LOOKUP,
		CMD_FIN_REUSE,
		CMD_FIN_QUICK,
		CMD_SCAN
	} gha_cmd_t;

	typedef struct packed {
		logic free_empty;
		logic next_invalid;
		logic out_free;
		logic scan_end;
	} gha_stat_t;

endpackage

### design/gha_req_if.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - request channel
// Valid/ready channel carrying one request transaction.
// ---------------------------------------------------------------------------
interface gha_req_if;

	logic                             valid;
	logic                             ready;
	logic [gha_pkg::FUNC_W-1:0]       func;
	logic [gha_pkg::IDX_W-1:0]        handle_index;
	logic [gha_pkg::GEN_BITS-1:0]     handle_version;

	modport source (
		output valid, func, handle_index, handle_version,
		input  ready
	);

	modport sink (
		input  valid, func, handle_index, handle_version,
		output ready
	);

endinterface

### design/gha_rsp_if.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - response channel
// Valid/ready channel carrying one result transaction.
// ---------------------------------------------------------------------------
interface gha_rsp_if;

	logic                             valid;
	logic                             ready;
	logic [gha_pkg::STATUS_W-1:0]     status;
	logic [gha_pkg::IDX_W-1:0]        out_index;
	logic [gha_pkg::GEN_BITS-1:0]     out_version;
	logic                             alive;

	modport source (
		output valid, status, out_index, out_version, alive,
		input  ready
	);

	modport sink (
		input  valid, status, out_index, out_version, alive,
		output ready
	);

endinterface

### design/gha_ram.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - generic RAM
// One write port, one read port, registered read data held when idle.
// ---------------------------------------------------------------------------
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/gha_ctrl.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - controller
// Sequences one request through lookup, reuse, quick or scan steps.
// ---------------------------------------------------------------------------
module gha_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [gha_pkg::FUNC_W-1:0]  in_func,
	output logic                        in_ready,
	input  gha_pkg::gha_stat_t          st,
	output gha_pkg::gha_cmd_t           cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_POP,
		S_REUSE,
		S_QUICK,
		S_SCAN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = gha_pkg::CMD_NONE;
		case (state_q)
			S_IDLE:   if (in_valid)    cmd = gha_pkg::CMD_ACCEPT;
			S_LOOKUP: if (st.out_free) cmd = gha_pkg::CMD_FIN_LOOKUP;
			S_POP:                     cmd = gha_pkg::CMD_POP_GEN;
			S_REUSE:  if (st.out_free) cmd = gha_pkg::CMD_FIN_REUSE;
			S_QUICK:  if (st.out_free) cmd = gha_pkg::CMD_FIN_QUICK;
			S_SCAN:   if (st.out_free) cmd = gha_pkg::CMD_SCAN;
			default:                   cmd = gha_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (gha_pkg::gha_func_t'(in_func))
							gha_pkg::FN_CREATE: state_q <= st.free_empty ? S_QUICK : S_POP;
							gha_pkg::FN_FREE,
							gha_pkg::FN_CHECK:  state_q <= S_LOOKUP;
							gha_pkg::FN_FIRST:  state_q <= S_SCAN;
							gha_pkg::FN_NEXT:   state_q <= st.next_invalid ? S_QUICK : S_SCAN;
							default:            state_q <= S_QUICK;
						endcase
					end
				end
				S_POP: state_q <= S_REUSE;
				S_LOOKUP,
				S_REUSE,
				S_QUICK: begin
					if (st.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (st.out_free && st.scan_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/gha_dp.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - datapath
// Generation table, free stack, counters, scan pipeline and result register.
// ---------------------------------------------------------------------------
module gha_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gha_pkg::gha_cmd_t             cmd,
	output gha_pkg::gha_stat_t            st,
	input  logic [gha_pkg::FUNC_W-1:0]    in_func,
	input  logic [gha_pkg::IDX_W-1:0]     in_index,
	input  logic [gha_pkg::GEN_BITS-1:0]  in_version,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [gha_pkg::STATUS_W-1:0]  out_status,
	output logic [gha_pkg::IDX_W-1:0]     out_index,
	output logic [gha_pkg::GEN_BITS-1:0]  out_version,
	output logic                          out_alive
);

	gha_pkg::gha_func_t               func_q;
	logic [gha_pkg::IDX_W-1:0]        idx_q;
	logic [gha_pkg::GEN_BITS-1:0]     ver_q;
	logic [gha_pkg::CNT_W-1:0]        free_cnt_q;
	logic [gha_pkg::CNT_W-1:0]        used_q;
	logic [gha_pkg::CNT_W-1:0]        scan_q;
	logic                             pend_s1;
	logic [gha_pkg::IDX_W-1:0]        pidx_s1;
	logic                             out_valid_q;
	gha_pkg::gha_status_t             status_q;
	logic [gha_pkg::IDX_W-1:0]        oidx_q;
	logic [gha_pkg::GEN_BITS-1:0]     over_q;
	logic                             alive_q;

	logic                             gen_we, gen_re;
	logic [gha_pkg::IDX_W-1:0]        gen_waddr, gen_raddr;
	logic [gha_pkg::GEN_BITS-1:0]     gen_wdata, gen_rdata, gen_inc;
	logic                             stk_we, stk_re;
	logic [gha_pkg::IDX_W-1:0]        stk_raddr, stk_rdata;
	logic [gha_pkg::CNT_W-1:0]        free_dec;

	logic                             lookup_live, used_full, stack_full;
	logic                             scan_issue, scan_hit, scan_none;
	logic                             res_we;
	gha_pkg::gha_status_t             res_status;
	logic [gha_pkg::IDX_W-1:0]        res_index;
	logic [gha_pkg::GEN_BITS-1:0]     res_version;
	logic                             res_alive;

	gha_ram #(
		.WIDTH (gha_pkg::GEN_BITS),
		.DEPTH (gha_pkg::SLOT_COUNT)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (gen_re),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	gha_ram #(
		.WIDTH (gha_pkg::IDX_W),
		.DEPTH (gha_pkg::SLOT_COUNT)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (free_cnt_q[gha_pkg::IDX_W-1:0]),
		.wdata (idx_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign gen_inc     = gen_rdata + gha_pkg::GEN_ONE;
	assign free_dec    = free_cnt_q - gha_pkg::CNT_W'(1);
	assign stk_raddr   = free_dec[gha_pkg::IDX_W-1:0];
	assign used_full   = (used_q == gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT));
	assign stack_full  = (free_cnt_q == gha_pkg::CNT_W'(gha_pkg::SLOT_COUNT));
	assign lookup_live = ({1'b0, idx_q} < used_q) && gen_rdata[0] && (gen_rdata == ver_q);
	assign scan_issue  = (scan_q < used_q);
	assign scan_hit    = pend_s1 && gen_rdata[0];
	assign scan_none   = !pend_s1 && !scan_issue;

	assign st.free_empty   = (free_cnt_q == '0);
	assign st.next_invalid = (in_version == '0);
	assign st.out_free     = !out_valid_q || out_ready;
	assign st.scan_end     = scan_hit || scan_none;

	always_comb begin
		gen_we      = 1'b0;
		gen_waddr   = idx_q;
		gen_wdata   = gen_inc;
		gen_re      = 1'b0;
		gen_raddr   = in_index;
		stk_we      = 1'b0;
		stk_re      = 1'b0;
		res_we      = 1'b0;
		res_status  = gha_pkg::ST_OK;
		res_index   = '0;
		res_version = '0;
		res_alive   = 1'b0;
		case (cmd)
			gha_pkg::CMD_ACCEPT: begin
				gen_re = (in_func == gha_pkg::FN_FREE) || (in_func == gha_pkg::FN_CHECK);
				stk_re = (in_func == gha_pkg::FN_CREATE) && !st.free_empty;
			end
			gha_pkg::CMD_POP_GEN: begin
				gen_re    = 1'b1;
				gen_raddr = stk_rdata;
			end
			gha_pkg::CMD_FIN_LOOKUP: begin
				res_we = 1'b1;
				if (lookup_live && !(func_q == gha_pkg::FN_FREE && stack_full)) begin
					res_alive = 1'b1;
					gen_we    = (func_q == gha_pkg::FN_FREE);
					stk_we    = (func_q == gha_pkg::FN_FREE);
				end else begin
					res_status = gha_pkg::ST_NOT_LIVE;
				end
			end
			gha_pkg::CMD_FIN_REUSE: begin
				res_we = 1'b1;
				if (gen_rdata >= gha_pkg::GEN_LIMIT) begin
					res_status = gha_pkg::ST_EXHAUSTED;
				end else begin
					gen_we      = 1'b1;
					res_index   = idx_q;
					res_version = gen_inc;
				end
			end
			gha_pkg::CMD_FIN_QUICK: begin
				res_we = 1'b1;
				case (func_q)
					gha_pkg::FN_CREATE: begin
						if (used_full) begin
							res_status = gha_pkg::ST_FULL;
						end else begin
							gen_we      = 1'b1;
							gen_waddr   = used_q[gha_pkg::IDX_W-1:0];
							gen_wdata   = gha_pkg::GEN_ONE;
							res_index   = used_q[gha_pkg::IDX_W-1:0];
							res_version = gha_pkg::GEN_ONE;
						end
					end
					gha_pkg::FN_NEXT: res_status = gha_pkg::ST_NONE;
					default:          res_status = gha_pkg::ST_OK;
				endcase
			end
			gha_pkg::CMD_SCAN: begin
				gen_re    = scan_issue;
				gen_raddr = scan_q[gha_pkg::IDX_W-1:0];
				if (scan_hit) begin
					res_we      = 1'b1;
					res_index   = pidx_s1;
					res_version = gen_rdata;
				end else if (scan_none) begin
					res_we     = 1'b1;
					res_status = gha_pkg::ST_NONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q      <= gha_pkg::FN_CREATE;
			free_cnt_q  <= '0;
			used_q      <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				gha_pkg::CMD_ACCEPT: begin
					func_q  <= gha_pkg::gha_func_t'(in_func);
					pend_s1 <= 1'b0;
					if (in_func == gha_pkg::FN_NEXT) begin
						scan_q <= {1'b0, in_index} + gha_pkg::CNT_W'(1);
					end else begin
						scan_q <= '0;
					end
				end
				gha_pkg::CMD_FIN_LOOKUP: begin
					if (stk_we) begin
						free_cnt_q <= free_cnt_q + gha_pkg::CNT_W'(1);
					end
				end
				gha_pkg::CMD_FIN_REUSE: free_cnt_q <= free_dec;
				gha_pkg::CMD_FIN_QUICK: begin
					if (func_q == gha_pkg::FN_CLEAR) begin
						free_cnt_q <= '0;
						used_q     <= '0;
					end else if (func_q == gha_pkg::FN_CREATE && !used_full) begin
						used_q <= used_q + gha_pkg::CNT_W'(1);
					end
				end
				gha_pkg::CMD_SCAN: begin
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						scan_q <= scan_q + gha_pkg::CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == gha_pkg::CMD_ACCEPT) begin
			idx_q <= in_index;
			ver_q <= in_version;
		end else if (cmd == gha_pkg::CMD_POP_GEN) begin
			idx_q <= stk_rdata;
		end
		if (cmd == gha_pkg::CMD_SCAN) begin
			pidx_s1 <= scan_q[gha_pkg::IDX_W-1:0];
		end
		if (res_we) begin
			status_q <= res_status;
			oidx_q   <= res_index;
			over_q   <= res_version;
			alive_q  <= res_alive;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = status_q;
	assign out_index   = oidx_q;
	assign out_version = over_q;
	assign out_alive   = alive_q;

endmodule

### design/generational_handle_allocator_top.sv
// Accept to result: check and free pass through lookup; clear, append-create, full,
// bad next and unused codes through quick; create from the free stack through pop
// and reuse (stack read, then table read-modify-write). First/next scan slot by slot
// up to the live slot found, or past the slots in use on a miss; finishing steps wait on a
// held result. One request in flight, taken the cycle after the result is registered.
// Reset clears counters and control only; table and free stack keep no reset values.
// ---------------------------------------------------------------------------
// Generational handle allocator - top level
// Slot/generation handle allocation with LIFO slot reuse and live-slot scans.
// ---------------------------------------------------------------------------
module generational_handle_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	gha_req_if.sink    req,
	gha_rsp_if.source  rsp
);

	gha_pkg::gha_cmd_t  cmd;
	gha_pkg::gha_stat_t st;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	gha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_func     (req.func),
		.in_index    (req.handle_index),
		.in_version  (req.handle_version),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_status  (rsp.status),
		.out_index   (rsp.out_index),
		.out_version (rsp.out_version),
		.out_alive   (rsp.alive)
	);

endmodule

### design/gha_chk.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - port checker
// Observes the top-level channels; bound to the top level.
// ---------------------------------------------------------------------------
`include "generational_handle_allocator_top_defines.svh"

module gha_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic [gha_pkg::STATUS_W-1:0]  rsp_status,
	input  logic [gha_pkg::IDX_W-1:0]     rsp_index,
	input  logic [gha_pkg::GEN_BITS-1:0]  rsp_version,
	input  logic                          rsp_alive
);

	// one request at a time
	`GHA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "ready after accept")

	`GHA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_index) && $stable(rsp_version) && $stable(rsp_alive), "stalled result changed")

	// failures carry no handle
	`GHA_ASSERT_IMP(a_fail_zero, clk, arst_n, rsp_valid && (rsp_status != gha_pkg::ST_OK), (rsp_index == '0) && (rsp_version == '0) && !rsp_alive, "failure with payload")

	// handed-out or found handles are always live
	`GHA_ASSERT_IMP(a_ver_odd, clk, arst_n, rsp_valid && (rsp_status == gha_pkg::ST_OK) && (rsp_version != '0), rsp_version[0], "even generation returned")

endmodule

bind generational_handle_allocator_top gha_chk u_gha_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_index   (rsp.out_index),
	.rsp_version (rsp.out_version),
	.rsp_alive   (rsp.alive)
);

### verif/generational_handle_allocator_top_test.sv
// ---------------------------------------------------------------------------
// Generational handle allocator - testbench
// Drives create, free, check, clear and live-slot scan requests with random
// gaps and response back-pressure. A behavioural model of the slot table
// and the LIFO free stack predicts every result, and each result is
// compared field by field in order. Covers table full, bad handles, empty
// scans and unused function codes.
// ---------------------------------------------------------------------------
module generational_handle_allocator_top_test;

	import gha_pkg::*;

	localparam logic [FUNC_W-1:0] FN_RESERVED_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RESERVED_B = 3'd7;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS = 60;

	typedef struct packed {
		gha_status_t          status;
		logic [IDX_W-1:0]     slot_index;
		logic [GEN_BITS-1:0]  slot_version;
		logic                 alive;
	} alloc_result_t;

	logic clk;
	logic arst_n;

	gha_req_if req_ch ();
	gha_rsp_if rsp_ch ();

	generational_handle_allocator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// model state
	logic [GEN_BITS-1:0] gen_of_slot [SLOT_COUNT];
	logic [IDX_W-1:0]    freed_slots [SLOT_COUNT];
	int                  freed_depth;
	int                  slots_in_use;

	alloc_result_t outcomes_due [$];

	int  mismatches;
	int  requests_sent;
	int  results_seen;
	int  status_seen [5];
	bit  gaps_on;
	int  burst_left;
	bit  stalls_on;
	int  hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- model

	function automatic bit slot_is_live(input logic [IDX_W-1:0] idx,
		input logic [GEN_BITS-1:0] ver);
		if (int'(idx) >= slots_in_use)
			return 1'b0;
		return gen_of_slot[idx][0] && gen_of_slot[idx] == ver;
	endfunction

	function automatic alloc_result_t scan_live_from(input int start);
		for (int i = start; i < slots_in_use; i++) begin
			if (gen_of_slot[i][0])
				return '{ST_OK, IDX_W'(i), gen_of_slot[i], 1'b0};
		end
		return '{ST_NONE, '0, '0, 1'b0};
	endfunction

	function automatic alloc_result_t handle_outcome(input logic [FUNC_W-1:0] fn,
		input logic [IDX_W-1:0] idx, input logic [GEN_BITS-1:0] ver);
		alloc_result_t       res;
		logic [IDX_W-1:0]    slot;
		logic [GEN_BITS-1:0] gen;
		res = '{ST_OK, '0, '0, 1'b0};
		case (fn)
			FN_CREATE: begin
				if (freed_depth > 0) begin
					freed_depth--;
					slot = freed_slots[freed_depth];
					gen = gen_of_slot[slot];
					if (gen >= GEN_LIMIT) begin
						res.status = ST_EXHAUSTED;
					end else begin
						gen = gen + GEN_ONE;
						gen_of_slot[slot] = gen;
						res.slot_index = slot;
						res.slot_version = gen;
					end
				end else if (slots_in_use >= SLOT_COUNT) begin
					res.status = ST_FULL;
				end else begin
					gen_of_slot[slots_in_use] = GEN_ONE;
					res.slot_index = IDX_W'(slots_in_use);
					res.slot_version = GEN_ONE;
					slots_in_use++;
				end
			end
			FN_FREE: begin
				if (!slot_is_live(idx, ver) || freed_depth >= SLOT_COUNT) begin
					res.status = ST_NOT_LIVE;
				end else begin
					gen_of_slot[idx] = gen_of_slot[idx] + GEN_ONE;
					freed_slots[freed_depth] = idx;
					freed_depth++;
					res.alive = 1'b1;
				end
			end
			FN_CHECK: begin
				if (slot_is_live(idx, ver))
					res.alive = 1'b1;
				else
					res.status = ST_NOT_LIVE;
			end
			FN_CLEAR: begin
				slots_in_use = 0;
				freed_depth = 0;
			end
			FN_FIRST: res = scan_live_from(0);
			FN_NEXT: begin
				if (ver == '0)
					res.status = ST_NONE;
				else
					res = scan_live_from(int'(idx) + 1);
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic bit pick_live_slot(output logic [IDX_W-1:0] slot);
		int start;
		int i;
		slot = '0;
		if (slots_in_use == 0)
			return 1'b0;
		start = $urandom_range(0, slots_in_use - 1);
		for (int k = 0; k < slots_in_use; k++) begin
			i = (start + k) % slots_in_use;
			if (gen_of_slot[i][0]) begin
				slot = IDX_W'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
		input logic [GEN_BITS-1:0] ver, output alloc_result_t outcome);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req_ch.valid          <= 1'b1;
		req_ch.func           <= fn;
		req_ch.handle_index   <= idx;
		req_ch.handle_version <= ver;
		do @(posedge clk); while (!req_ch.ready);
		outcome = handle_outcome(fn, idx, ver);
		outcomes_due.insert(outcomes_due.size(), outcome);
		status_seen[int'(outcome.status)]++;
		requests_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outcomes_due.size() != 0);
	endtask

	initial begin
		int seg_left;
		int pattern;
		int hold_left;
		int cyc;
		seg_left = 0;
		pattern = 0;
		hold_left = 0;
		cyc = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (!stalls_on) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					pattern = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 60);
				end
				seg_left--;
				case (pattern)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 9) < 6);
					default: rsp_ch.ready <= (cyc % 3 != 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- result check

	initial begin
		alloc_result_t want;
		alloc_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got = '{gha_status_t'(rsp_ch.status), rsp_ch.out_index, rsp_ch.out_version,
					rsp_ch.alive};
				results_seen++;
				if (outcomes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: status %0d index %0d version %0d alive %0d",
							got.status, got.slot_index, got.slot_version, got.alive);
				end else begin
					want = outcomes_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"mismatch: status exp %0d got %0d, index exp %0d got %0d, ",
								"version exp %0d got %0d, alive exp %0d got %0d"},
								want.status, got.status, want.slot_index, got.slot_index,
								want.slot_version, got.slot_version, want.alive, got.alive);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_directed_cases();
		alloc_result_t r;
		issue_request(FN_CHECK, 10'd0, 16'd1, r);
		issue_request(FN_FIRST, 10'd0, 16'd0, r);
		issue_request(FN_NEXT, 10'd0, 16'd0, r);
		issue_request(FN_FREE, 10'd1023, 16'hFFFF, r);
		issue_request(FN_RESERVED_A, 10'd1023, 16'hFFFF, r);
		issue_request(FN_RESERVED_B, 10'd512, 16'h8000, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_CHECK, 10'd1, 16'd1, r);
		issue_request(FN_CHECK, 10'd1, 16'd3, r);
		issue_request(FN_CHECK, 10'd3, 16'd1, r);
		issue_request(FN_FREE, 10'd1, 16'd1, r);
		issue_request(FN_FREE, 10'd1, 16'd1, r);
		issue_request(FN_CHECK, 10'd1, 16'd2, r);
		issue_request(FN_NEXT, 10'd0, 16'd1, r);
		issue_request(FN_FREE, 10'd2, 16'd1, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_NEXT, 10'd2, 16'd3, r);
		issue_request(FN_NEXT, 10'd1023, 16'hFFFF, r);
		issue_request(FN_CLEAR, 10'd0, 16'd0, r);
		issue_request(FN_FIRST, 10'd0, 16'd0, r);
		issue_request(FN_CHECK, 10'd0, 16'd1, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		wait_results_drained();
	endtask

	task automatic test_full_table();
		alloc_result_t r;
		issue_request(FN_CLEAR, 10'd0, 16'd0, r);
		for (int i = 0; i < SLOT_COUNT; i++)
			issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_CHECK, 10'd1023, 16'd1, r);
		issue_request(FN_FIRST, 10'd0, 16'd0, r);
		issue_request(FN_FREE, 10'd5, 16'd1, r);
		issue_request(FN_FREE, 10'd700, 16'd1, r);
		issue_request(FN_FREE, 10'd1023, 16'd1, r);
		issue_request(FN_NEXT, 10'd4, 16'd1, r);
		issue_request(FN_NEXT, 10'd1022, 16'd1, r);
		// LIFO reuse: 1023, 700, 5
		repeat (3) issue_request(FN_CREATE, 10'd0, 16'd0, r);
		issue_request(FN_CREATE, 10'd0, 16'd0, r);
		for (int i = 0; i < 16; i++)
			issue_request(FN_FREE, IDX_W'(i), gen_of_slot[i], r);
		issue_request(FN_FIRST, 10'd0, 16'd0, r);
		issue_request(FN_NEXT, 10'd1000, 16'd1, r);
		issue_request(FN_CLEAR, 10'd0, 16'd0, r);
		wait_results_drained();
	endtask

	task automatic test_backpressure();
		alloc_result_t r;
		hold_request = 300;
		for (int i = 0; i < 16; i++) begin
			case (i % 4)
				0: issue_request(FN_CREATE, 10'd0, 16'd0, r);
				1: issue_request(FN_CHECK, 10'(i / 4), 16'd1, r);
				2: issue_request(FN_FIRST, 10'd0, 16'd0, r);
				default: issue_request(FN_NEXT, 10'd0, 16'd1, r);
			endcase
		end
		wait_results_drained();
	endtask

	task automatic test_random_traffic();
		alloc_result_t       r;
		logic [FUNC_W-1:0]   fn;
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] ver;
		logic [IDX_W-1:0]    slot;
		int                  pick;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 20 == 19) begin
				gaps_on = $urandom_range(0, 2) != 0;
				if ($urandom_range(0, 3) == 0)
					wait_results_drained();
			end
			pick = $urandom_range(0, 99);
			fn = FN_CREATE;
			idx = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
			ver = GEN_BITS'($urandom_range(0, 65535));
			if (pick < 28) begin
				fn = FN_CREATE;
			end else if (pick < 58) begin
				fn = (pick < 46) ? FN_FREE : FN_CHECK;
				if (pick_live_slot(slot)) begin
					idx = slot;
					ver = gen_of_slot[slot];
				end else begin
					fn = FN_CREATE;
				end
			end else if (pick < 66) begin
				// stale or off-by-a-little handles
				fn = (pick < 62) ? FN_CHECK : FN_FREE;
				if (slots_in_use > 0) begin
					idx = IDX_W'($urandom_range(0, slots_in_use));
					ver = gen_of_slot[idx] + GEN_BITS'($urandom_range(0, 3));
				end
			end else if (pick < 70) begin
				fn = (pick < 68) ? FN_CHECK : FN_FREE;
			end else if (pick < 76) begin
				fn = FN_FIRST;
			end else if (pick < 88) begin
				fn = FN_NEXT;
				if (pick < 84 && pick_live_slot(slot)) begin
					idx = slot;
					ver = gen_of_slot[slot];
				end else if ($urandom_range(0, 5) == 0) begin
					ver = '0;
				end
			end else if (pick < 91) begin
				fn = FN_CLEAR;
			end else if (pick < 93) begin
				fn = $urandom_range(0, 1) ? FN_RESERVED_A : FN_RESERVED_B;
			end else begin
				fn = FN_CHECK;
			end
			issue_request(fn, idx, ver, r);
		end
		wait_results_drained();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			gen_of_slot[i] = '0;
			freed_slots[i] = '0;
		end
		freed_depth = 0;
		slots_in_use = 0;
		mismatches = 0;
		requests_sent = 0;
		results_seen = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		gaps_on = 1'b1;
		burst_left = 0;
		stalls_on = 1'b1;
		hold_request = 0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_CREATE;
		req_ch.handle_index = '0;
		req_ch.handle_version = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_table();
		test_backpressure();
		test_random_traffic();

		repeat (20) @(posedge clk);
		$display("Run covered %0d requests and %0d results, including a full table,",
			requests_sent, results_seen);
		$display("bad handles and live-slot scans; ok %0d, not live %0d, full %0d, none %0d",
			status_seen[ST_OK], status_seen[ST_NOT_LIVE], status_seen[ST_FULL],
			status_seen[ST_NONE]);
		if (mismatches == 0 && outcomes_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
